// ===== design/sbr_pkg.sv =====
// Shared types, codes and header sizes for the segmented buffer reassembler.
package sbr_pkg;

   localparam int unsigned BEGIN_HEADER_BYTES = 12;
   localparam int unsigned DATA_HEADER_BYTES  = 4;

   localparam logic [1:0] CMD_ARM    = 2'd0;
   localparam logic [1:0] CMD_CANCEL = 2'd1;
   localparam logic [1:0] CMD_HEADER = 2'd2;

   localparam logic [7:0] KIND_BEGIN = 8'h10;
   localparam logic [7:0] KIND_DATA  = 8'h11;

   localparam logic [3:0] ST_SEGMENT_OK        = 4'd0;
   localparam logic [3:0] ST_COMPLETE          = 4'd1;
   localparam logic [3:0] ST_ARMED             = 4'd2;
   localparam logic [3:0] ST_CANCELLED         = 4'd3;
   localparam logic [3:0] ST_NOTHING_TO_CANCEL = 4'd4;
   localparam logic [3:0] ST_ALREADY_ARMED     = 4'd5;
   localparam logic [3:0] ST_NO_RECEIVER       = 4'd6;
   localparam logic [3:0] ST_TOO_BIG           = 4'd7;
   localparam logic [3:0] ST_NOT_EXPECTING     = 4'd8;
   localparam logic [3:0] ST_OVERRUN           = 4'd9;
   localparam logic [3:0] ST_UNKNOWN           = 4'd10;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] capacity;
      logic [7:0]  packet_kind;
      logic [15:0] packet_bytes;
      logic [7:0]  announced_type;
      logic [31:0] announced_size;
      logic [31:0] announced_checksum;
   } sbr_req_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [31:0] write_offset;
      logic [15:0] copy_length;
      logic        done_signal;
      logic [7:0]  buffer_type;
      logic [31:0] expected_checksum;
      logic [31:0] received_total;
   } sbr_rsp_type;

endpackage

// ===== design/sbr_if.sv =====
// Request and response channel interfaces of the segmented buffer reassembler.
interface sbr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [31:0] capacity;
   logic [7:0]  packet_kind;
   logic [15:0] packet_bytes;
   logic [7:0]  announced_type;
   logic [31:0] announced_size;
   logic [31:0] announced_checksum;

   modport source (
      output valid, command, capacity, packet_kind, packet_bytes,
             announced_type, announced_size, announced_checksum,
      input  ready
   );
   modport sink (
      input  valid, command, capacity, packet_kind, packet_bytes,
             announced_type, announced_size, announced_checksum,
      output ready
   );
endinterface

interface sbr_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  status;
   logic [31:0] write_offset;
   logic [15:0] copy_length;
   logic        done_signal;
   logic [7:0]  buffer_type;
   logic [31:0] expected_checksum;
   logic [31:0] received_total;

   modport source (
      output valid, status, write_offset, copy_length, done_signal,
             buffer_type, expected_checksum, received_total,
      input  ready
   );
   modport sink (
      input  valid, status, write_offset, copy_length, done_signal,
             buffer_type, expected_checksum, received_total,
      output ready
   );
endinterface

// ===== design/sbr_in_stage.sv =====
// Input register stage: captures one request and holds it until the engine takes it.
module sbr_in_stage (
   input  logic                clock,
   input  logic                reset,
   sbr_req_if.sink             req_bus,
   input  logic                take,
   output logic                item_valid,
   output sbr_pkg::sbr_req_type item
);
   import sbr_pkg::*;

   logic        valid_ff, valid_in;
   sbr_req_type item_ff;
   logic        load;

   assign req_bus.ready = !valid_ff || take;
   assign load          = req_bus.valid && req_bus.ready;
   assign valid_in      = load || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.command            <= req_bus.command;
         item_ff.capacity           <= req_bus.capacity;
         item_ff.packet_kind        <= req_bus.packet_kind;
         item_ff.packet_bytes       <= req_bus.packet_bytes;
         item_ff.announced_type     <= req_bus.announced_type;
         item_ff.announced_size     <= req_bus.announced_size;
         item_ff.announced_checksum <= req_bus.announced_checksum;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== design/sbr_engine.sv =====
// Receive state and the combinational decision for one request.
module sbr_engine #(
   parameter int unsigned BeginHeaderBytes = sbr_pkg::BEGIN_HEADER_BYTES,
   parameter int unsigned DataHeaderBytes  = sbr_pkg::DATA_HEADER_BYTES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  sbr_pkg::sbr_req_type item,
   output sbr_pkg::sbr_rsp_type result
);
   import sbr_pkg::*;

   localparam logic [15:0] BeginHdr = 16'(BeginHeaderBytes);
   localparam logic [15:0] DataHdr  = 16'(DataHeaderBytes);

   logic        armed_ff, armed_in;
   logic [31:0] storage_limit_ff, storage_limit_in;
   logic [31:0] expected_size_ff, expected_size_in;
   logic [31:0] received_count_ff, received_count_in;
   logic [7:0]  latched_type_ff, latched_type_in;
   logic [31:0] latched_checksum_ff, latched_checksum_in;

   logic        is_begin;
   logic [15:0] hdr_len;
   logic [31:0] base_exp;
   logic [31:0] base_rcv;
   logic [31:0] missing;
   logic [15:0] seg_len;
   logic        overrun;
   logic [31:0] new_rcv;

   // Segment arithmetic, shared by begin and data packets
   assign is_begin = (item.packet_kind == KIND_BEGIN);
   assign hdr_len  = is_begin ? BeginHdr : DataHdr;
   assign base_exp = is_begin ? item.announced_size : expected_size_ff;
   assign base_rcv = is_begin ? 32'd0 : received_count_ff;
   assign missing  = base_exp - base_rcv;
   assign seg_len  = item.packet_bytes - hdr_len;
   assign overrun  = (item.packet_bytes < hdr_len) || ({16'd0, seg_len} > missing);
   assign new_rcv  = base_rcv + {16'd0, seg_len};

   always_comb begin
      armed_in            = armed_ff;
      storage_limit_in    = storage_limit_ff;
      expected_size_in    = expected_size_ff;
      received_count_in   = received_count_ff;
      latched_type_in     = latched_type_ff;
      latched_checksum_in = latched_checksum_ff;
      result.status       = ST_UNKNOWN;
      result.write_offset = 32'd0;
      result.copy_length  = 16'd0;
      result.done_signal  = 1'b0;

      unique case (item.command)
         CMD_ARM: begin
            if (armed_ff) begin
               result.status = ST_ALREADY_ARMED;
            end else begin
               armed_in          = 1'b1;
               storage_limit_in  = item.capacity;
               expected_size_in  = 32'd0;
               received_count_in = 32'd0;
               result.status     = ST_ARMED;
            end
         end
         CMD_CANCEL: begin
            if (!armed_ff) begin
               result.status = ST_NOTHING_TO_CANCEL;
            end else begin
               armed_in           = 1'b0;
               expected_size_in   = 32'd0;
               received_count_in  = 32'd0;
               result.done_signal = 1'b1;
               result.status      = ST_CANCELLED;
            end
         end
         CMD_HEADER: begin
            if (!is_begin && item.packet_kind != KIND_DATA) begin
               result.status = ST_UNKNOWN;
            end else if (!armed_ff) begin
               result.status = ST_NO_RECEIVER;
            end else if (is_begin && item.announced_size > storage_limit_ff) begin
               result.status = ST_TOO_BIG;
            end else begin
               if (is_begin) begin
                  latched_type_in     = item.announced_type;
                  expected_size_in    = item.announced_size;
                  received_count_in   = 32'd0;
                  latched_checksum_in = item.announced_checksum;
               end
               priority if (base_exp == 32'd0) begin
                  result.status = ST_NOT_EXPECTING;
               end else if (overrun) begin
                  // drop the whole buffer, stay armed
                  expected_size_in    = 32'd0;
                  received_count_in   = 32'd0;
                  latched_checksum_in = 32'd0;
                  result.status       = ST_OVERRUN;
               end else begin
                  result.write_offset = base_rcv;
                  result.copy_length  = seg_len;
                  received_count_in   = new_rcv;
                  if (new_rcv == base_exp) begin
                     armed_in           = 1'b0;
                     result.done_signal = 1'b1;
                     result.status      = ST_COMPLETE;
                  end else begin
                     result.status = ST_SEGMENT_OK;
                  end
               end
            end
         end
         default: begin
            result.status = ST_UNKNOWN;
         end
      endcase

      result.buffer_type       = latched_type_in;
      result.expected_checksum = latched_checksum_in;
      result.received_total    = received_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff            <= 1'b0;
         storage_limit_ff    <= 32'd0;
         expected_size_ff    <= 32'd0;
         received_count_ff   <= 32'd0;
         latched_type_ff     <= 8'd0;
         latched_checksum_ff <= 32'd0;
      end else if (fire) begin
         armed_ff            <= armed_in;
         storage_limit_ff    <= storage_limit_in;
         expected_size_ff    <= expected_size_in;
         received_count_ff   <= received_count_in;
         latched_type_ff     <= latched_type_in;
         latched_checksum_ff <= latched_checksum_in;
      end
   end

endmodule

// ===== design/segmented_buffer_reassembler_core.sv =====
// Top level of the segmented buffer reassembler: input stage, engine and response register.
// Takes one request per clock while responses are taken, and returns exactly one
// response per request, in order. A request passes an input register, is decided
// combinationally against the receive state by add/compare logic, and lands in the
// response register, so the sustained rate is one request per cycle while the consumer
// keeps up. The response register frees while the consumer takes the pending response,
// so a stalled consumer holds at most one response plus one request in the input
// register. Arm opens a receive, cancel closes it, and each packet header gets a storage
// offset and segment length, drops the buffer on overrun, or is refused with a status.
module segmented_buffer_reassembler_core #(
   parameter int unsigned BeginHeaderBytes = sbr_pkg::BEGIN_HEADER_BYTES,
   parameter int unsigned DataHeaderBytes  = sbr_pkg::DATA_HEADER_BYTES
) (
   input  logic     clock,
   input  logic     reset,
   sbr_req_if.sink  req_bus,
   sbr_rsp_if.source rsp_bus
);
   import sbr_pkg::*;

   logic        item_valid;
   sbr_req_type item;
   sbr_rsp_type result;
   logic        out_free;
   logic        fire;

   logic        rsp_valid_ff, rsp_valid_in;
   sbr_rsp_type rsp_ff;

   sbr_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .take       (fire),
      .item_valid (item_valid),
      .item       (item)
   );

   sbr_engine #(
      .BeginHeaderBytes (BeginHeaderBytes),
      .DataHeaderBytes  (DataHeaderBytes)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item),
      .result (result)
   );

   assign out_free     = !rsp_valid_ff || rsp_bus.ready;
   assign fire         = item_valid && out_free;
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.status            = rsp_ff.status;
   assign rsp_bus.write_offset      = rsp_ff.write_offset;
   assign rsp_bus.copy_length       = rsp_ff.copy_length;
   assign rsp_bus.done_signal       = rsp_ff.done_signal;
   assign rsp_bus.buffer_type       = rsp_ff.buffer_type;
   assign rsp_bus.expected_checksum = rsp_ff.expected_checksum;
   assign rsp_bus.received_total    = rsp_ff.received_total;

endmodule
